// ===== hdl/pack_nchw_to_blocked_channels_assert.svh =====
// Assertion macros shared by the layout packer.
`ifndef PACK_NCHW_TO_BLOCKED_CHANNELS_ASSERT_SVH
`define PACK_NCHW_TO_BLOCKED_CHANNELS_ASSERT_SVH
// Property that holds on every clock edge outside reset.
`define PNB_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);
// Implication checked in the next cycle.
`define PNB_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);
`endif

// ===== hdl/pnb_pkg.sv =====
// ----------------------------------------------------------------------------
// pnb_pkg
// Types and constants for the NCHW to channel-blocked layout packer.
// ----------------------------------------------------------------------------
package pnb_pkg;

  localparam logic [2:0] REG_BATCH   = 3'd0;
  localparam logic [2:0] REG_CHANNEL = 3'd1;
  localparam logic [2:0] REG_SPATIAL = 3'd2;
  localparam logic [2:0] REG_BLOCK   = 3'd3;
  localparam logic [2:0] REG_FORMAT  = 3'd4;

  localparam logic [1:0] FMT_COPY32 = 2'd0;
  localparam logic [1:0] FMT_COPY16 = 2'd1;
  localparam logic [1:0] FMT_CVT16  = 2'd2;
  // Unused mode; behaves as a 32-bit copy.
  localparam logic [1:0] FMT_SPARE  = 2'd3;

  typedef struct packed {
    logic [7:0]  batch_index;
    logic [11:0] channel_index;
    logic [19:0] spatial_index;
    logic [31:0] src_value;
  } in_item_t;

  typedef struct packed {
    logic [39:0] dst_index;
    logic [31:0] dst_value;
    logic        is_padding;
    logic        out_of_range;
  } out_item_t;

  // IEEE half from single, round to nearest even.
  function automatic logic [15:0] f32_to_f16(input logic [31:0] x);
    logic        sgn;
    logic [7:0]  e;
    logic [22:0] m;
    logic [23:0] full;
    logic [23:0] rem;
    logic [23:0] half;
    logic [23:0] mask;
    logic [10:0] h;
    logic [4:0]  sh;
    logic [15:0] r;
    sgn  = x[31];
    e    = x[30:23];
    m    = x[22:0];
    full = {1'b1, m};
    h    = '0;
    sh   = '0;
    rem  = '0;
    half = '0;
    mask = '0;
    if (e == 8'hFF) begin
      r = (m != '0) ? {sgn, 5'h1F, 1'b1, m[21:13]} : {sgn, 15'h7C00};
    end else if (e == 8'd0) begin
      r = {sgn, 15'd0};
    end else if (e >= 8'd143) begin
      r = {sgn, 15'h7C00};
    end else if (e >= 8'd113) begin
      // Normal result; carry may spill into exponent, giving infinity.
      r = {sgn, 15'({e - 8'd112, m[22:13]})};
      if (m[12:0] > 13'h1000 || (m[12:0] == 13'h1000 && m[13]))
        r = r + 16'd1;
    end else if (e < 8'd102) begin
      r = {sgn, 15'd0};
    end else begin
      // Subnormal: shift = 126 - e, from 14 to 24.
      sh   = 5'(8'd126 - e);
      h    = 11'(full >> sh);
      mask = (24'd1 << sh) - 24'd1;
      rem  = full & mask;
      half = 24'd1 << (sh - 5'd1);
      if (rem > half || (rem == half && h[0]))
        h = h + 11'd1;
      r = {sgn, 4'd0, h};
    end
    return r;
  endfunction

endpackage

// ===== hdl/pnb_value_conv.sv =====
// ----------------------------------------------------------------------------
// pnb_value_conv
// Registered value formatter: copy 32, copy 16, or fp32 to fp16.
// ----------------------------------------------------------------------------
module pnb_value_conv import pnb_pkg::*; (
  input  logic        clk,
  input  logic        en,
  input  logic [1:0]  mode,
  input  logic        zero,
  input  logic [31:0] src,
  output logic [31:0] dst
);

  logic [31:0] dst_next;

  // Select the formatted value; padding gives zero.
  always_comb begin
    case (mode)
      FMT_COPY16: dst_next = {16'd0, src[15:0]};
      FMT_CVT16:  dst_next = {16'd0, f32_to_f16(src)};
      default:    dst_next = src;
    endcase
    if (zero) dst_next = '0;
  end

  always_ff @(posedge clk) begin
    if (en) dst <= dst_next;
  end

endmodule

// ===== hdl/pack_nchw_to_blocked_channels.sv =====
// Path: an accepted input beat passes through stages 1, 2, 3 and 4 to its output beat.
// Throughput: one beat per cycle; a four-stage pipeline with a valid per stage,
// the whole pipe holds while the output is stalled and stage 4 is full.
// Reset (rst, synchronous) empties the pipe and restores the register defaults:
// batch 1, channels 8, spatial 1, block 8, 32-bit copy.
// ----------------------------------------------------------------------------
// pack_nchw_to_blocked_channels
// Maps NCHW elements to their channel-blocked index and written value.
// ----------------------------------------------------------------------------
`include "pack_nchw_to_blocked_channels_assert.svh"
module pack_nchw_to_blocked_channels import pnb_pkg::*; #(
  parameter int MAX_BATCH    = 256,
  parameter int MAX_CHANNELS = 4096,
  parameter int MAX_SPATIAL  = 1048576
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  in_item_t    in_data,
  output logic        out_valid,
  input  logic        out_stall,
  output out_item_t   out_data,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [31:0] cfg_data
);

  // Configuration registers.
  logic [8:0]  batch_count;
  logic [12:0] channel_count;
  logic [20:0] spatial_size;
  logic        block_select;
  logic [1:0]  format_mode;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      batch_count   <= 9'd1;
      channel_count <= 13'd8;
      spatial_size  <= 21'd1;
      block_select  <= 1'b1;
      format_mode   <= FMT_COPY32;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_BATCH:   batch_count   <= (cfg_data[8:0] > 9'(MAX_BATCH)) ?
                                      9'(MAX_BATCH) : cfg_data[8:0];
        REG_CHANNEL: channel_count <= (cfg_data[12:0] > 13'(MAX_CHANNELS)) ?
                                      13'(MAX_CHANNELS) : cfg_data[12:0];
        REG_SPATIAL: spatial_size  <= (cfg_data[20:0] > 21'(MAX_SPATIAL)) ?
                                      21'(MAX_SPATIAL) : cfg_data[20:0];
        REG_BLOCK:   block_select  <= cfg_data[0];
        REG_FORMAT:  format_mode   <= cfg_data[1:0];
        default: ;
      endcase
    end
  end

  // Padded channel count, derived from the registers.
  logic [13:0] padc;
  always_comb begin
    if (block_select) padc = 14'({channel_count + 13'd7} >> 3) << 3;
    else padc = 14'({channel_count + 13'd3} >> 2) << 2;
  end

  // Pipeline advance: the whole pipe moves unless stage 4 is full and the output is stalled.
  logic adv;
  logic v1, v2, v3, v4;
  assign adv       = !(v4 && out_stall);
  assign in_stall  = !adv;
  assign out_valid = v4;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0; v2 <= 1'b0; v3 <= 1'b0; v4 <= 1'b0;
    end else if (adv) begin
      v1 <= in_valid; v2 <= v1; v3 <= v2; v4 <= v3;
    end
  end

  // Stage 1: range checks and block split.
  logic        s1_oor, s1_pad;
  logic [7:0]  s1_b;
  logic [9:0]  s1_cblk;
  logic [2:0]  s1_clo;
  logic [19:0] s1_s;
  logic [31:0] s1_v;
  always_ff @(posedge clk) begin
    if (adv) begin
      s1_oor  <= ({1'b0, in_data.batch_index} >= batch_count) ||
                 ({2'b0, in_data.channel_index} >= padc) ||
                 ({1'b0, in_data.spatial_index} >= spatial_size);
      s1_pad  <= {1'b0, in_data.channel_index} >= channel_count;
      s1_b    <= in_data.batch_index;
      s1_cblk <= block_select ? {1'b0, in_data.channel_index[11:3]}
                              : in_data.channel_index[11:2];
      s1_clo  <= block_select ? in_data.channel_index[2:0]
                              : {1'b0, in_data.channel_index[1:0]};
      s1_s    <= in_data.spatial_index;
      s1_v    <= in_data.src_value;
    end
  end

  // Stage 2: products b*padC and cblk*S; value formatting.
  logic        s2_oor, s2_pad;
  logic [21:0] s2_bp;
  logic [30:0] s2_cs;
  logic [22:0] s2_sb;
  logic [31:0] s2_val;
  always_ff @(posedge clk) begin
    if (adv) begin
      s2_oor <= s1_oor;
      s2_pad <= s1_pad;
      s2_bp  <= 22'(s1_b) * 22'(padc);
      s2_cs  <= 31'(s1_cblk) * 31'(spatial_size);
      s2_sb  <= (block_select ? {s1_s, 3'd0} : {1'b0, s1_s, 2'd0}) + 23'(s1_clo);
    end
  end

  pnb_value_conv u_conv (
    .clk  (clk),
    .en   (adv),
    .mode (format_mode),
    .zero (s1_pad || s1_oor),
    .src  (s1_v),
    .dst  (s2_val)
  );

  // Stage 3: (b*padC)*S and block scaling.
  logic        s3_oor, s3_pad;
  logic [42:0] s3_bps;
  logic [33:0] s3_csb;
  logic [22:0] s3_sb;
  logic [31:0] s3_val;
  always_ff @(posedge clk) begin
    if (adv) begin
      s3_oor <= s2_oor;
      s3_pad <= s2_pad;
      s3_bps <= 43'(s2_bp) * 43'(spatial_size);
      s3_csb <= block_select ? {s2_cs, 3'd0} : {1'b0, s2_cs, 2'd0};
      s3_sb  <= s2_sb;
      s3_val <= s2_val;
    end
  end

  // Stage 4: final sum and output register.
  always_ff @(posedge clk) begin
    if (adv) begin
      out_data.dst_index    <= s3_oor ? 40'd0 :
                               40'(s3_bps + 43'(s3_csb) + 43'(s3_sb));
      out_data.dst_value    <= s3_val;
      out_data.is_padding   <= s3_pad && !s3_oor;
      out_data.out_of_range <= s3_oor;
    end
  end

  `PNB_ASSERT_ALWAYS(a_stall_only_full, !in_stall || out_valid, "stall with empty output")
  `PNB_ASSERT_NEXT(a_hold_out, out_valid && out_stall, out_valid && $stable(out_data),
                   "stalled output changed")
  `PNB_ASSERT_ALWAYS(a_oor_clean, !(out_valid && out_data.out_of_range) ||
                     (out_data.dst_index == 40'd0 && !out_data.is_padding),
                     "out of range result not cleared")

endmodule
